### hw/rtl/twwa_pkg.sv
// ----------------------------------------------------------------------------
// twwa_pkg
// Shared constants and types for the per-tank windowed weight averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package twwa_pkg;

   localparam int NUM_TANKS   = 32;
   localparam int WINDOW_MAX  = 32;
   localparam int TANK_W      = 5;
   localparam int POS_W       = 5;
   localparam int LEN_W       = 6;
   localparam int WEIGHT_W    = 16;
   localparam int ADDR_W      = TANK_W + POS_W;
   localparam int RING_DEPTH  = NUM_TANKS * WINDOW_MAX;
   localparam int SUM_W       = 21;
   localparam int DIVCNT_W    = 5;
   localparam logic [LEN_W-1:0] WINDOW_RESET = 6'd17;

   typedef struct packed {
      logic [TANK_W-1:0] tank_echo;
      logic [TANK_W-1:0] tank;
      logic [LEN_W-1:0]  count;
      logic              present;
      logic              changed;
   } twwa_job_type;

   typedef struct packed {
      logic sum_busy;
   } twwa_back_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SUM,
      BK_DIV,
      BK_DONE
   } twwa_state_type;

endpackage
`default_nettype wire

### hw/rtl/twwa_req_if.sv
// ----------------------------------------------------------------------------
// twwa_req_if
// Sample channel: valid/ready handshake carrying one weight sample word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface twwa_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  tank_index;
   logic [15:0] weight_sample;
   logic        inserted_now;
   logic        has_sensor;

   modport source (output valid, tank_index, weight_sample, inserted_now, has_sensor,
                   input ready);
   modport sink   (input valid, tank_index, weight_sample, inserted_now, has_sensor,
                   output ready);
endinterface
`default_nettype wire

### hw/rtl/twwa_rsp_if.sv
// ----------------------------------------------------------------------------
// twwa_rsp_if
// Result channel: valid/ready handshake carrying one average word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface twwa_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  tank_echo;
   logic [15:0] average_weight;
   logic [5:0]  readings_used;
   logic        tank_present;
   logic        presence_changed;

   modport source (output valid, tank_echo, average_weight, readings_used, tank_present,
                   presence_changed, input ready);
   modport sink   (input valid, tank_echo, average_weight, readings_used, tank_present,
                   presence_changed, output ready);
endinterface
`default_nettype wire

### hw/rtl/twwa_ram.sv
// ----------------------------------------------------------------------------
// twwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module twwa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### hw/rtl/twwa_front.sv
// ----------------------------------------------------------------------------
// twwa_front
// Accepts samples, updates per-tank ring bookkeeping, stores the weight and
// queues a job for the averaging back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module twwa_front import twwa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   twwa_req_if.sink                  req_if,
   input  wire logic [LEN_W-1:0]     window_len,
   input  wire logic                 queue_empty,
   input  wire twwa_back_status_type back_status,
   output      logic                 push,
   output      twwa_job_type         job,
   output      logic                 ram_wr_en,
   output      logic [ADDR_W-1:0]    ram_wr_addr,
   output      logic [WEIGHT_W-1:0]  ram_wr_data
);
   logic [POS_W-1:0] wpos_ff [NUM_TANKS];
   logic             full_ff [NUM_TANKS];
   logic             pres_ff [NUM_TANKS];

   logic [TANK_W-1:0] tank;
   logic [LEN_W-1:0]  len;
   logic              changed;
   logic [POS_W-1:0]  pos;
   logic              last;
   logic              full_in;
   logic [POS_W-1:0]  pos_in;
   logic              pres_in;
   logic              accept;

   // Only one word is in flight between the table update and the ring sweep,
   // so the back end never reads a ring that is being rewritten.
   assign req_if.ready = queue_empty && !back_status.sum_busy;
   assign accept       = req_if.valid && req_if.ready;
   assign tank         = req_if.tank_index;

   always_comb begin
      if (window_len == '0) begin
         len = LEN_W'(1);
      end else if (window_len > LEN_W'(WINDOW_MAX)) begin
         len = LEN_W'(WINDOW_MAX);
      end else begin
         len = window_len;
      end
      changed = req_if.has_sensor && (pres_ff[tank] != req_if.inserted_now);
      pos     = changed ? '0 : wpos_ff[tank];
      if ({1'b0, pos} >= len) begin
         pos = '0;
      end
      last    = ({1'b0, pos} == (len - LEN_W'(1)));
      full_in = (changed ? 1'b0 : full_ff[tank]) | last;
      pos_in  = last ? '0 : pos + POS_W'(1);
      pres_in = req_if.has_sensor ? req_if.inserted_now : pres_ff[tank];
   end

   assign push          = accept;
   assign job.tank_echo = req_if.tank_index;
   assign job.tank      = tank;
   assign job.count     = full_in ? len : {1'b0, pos_in};
   assign job.present   = pres_in;
   assign job.changed   = changed;
   assign ram_wr_en     = accept;
   assign ram_wr_addr   = {tank, pos};
   assign ram_wr_data   = req_if.weight_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TANKS; i++) begin
            wpos_ff[i] <= '0;
            full_ff[i] <= 1'b0;
            pres_ff[i] <= 1'b0;
         end
      end else if (accept) begin
         wpos_ff[tank] <= pos_in;
         full_ff[tank] <= full_in;
         pres_ff[tank] <= pres_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/twwa_queue.sv
// ----------------------------------------------------------------------------
// twwa_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module twwa_queue import twwa_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire twwa_job_type push_job,
   input  wire logic         pop,
   output      twwa_job_type head_job,
   output      logic         empty
);
   twwa_job_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   fill_ff;
   logic         do_push;
   logic         do_pop;

   assign empty    = (fill_ff == 2'd0);
   assign head_job = entry_ff[rd_ptr_ff];
   assign do_push  = push && (fill_ff != 2'd2);
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_ff + 2'(do_push) - 2'(do_pop);
      end
   end
endmodule
`default_nettype wire

### hw/rtl/twwa_back.sv
// ----------------------------------------------------------------------------
// twwa_back
// Sums the valid ring entries of a tank, divides by the entry count with a
// bit-serial divider and presents the result through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module twwa_back import twwa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire twwa_job_type         head_job,
   input  wire logic                 queue_empty,
   output      logic                 pop,
   output      twwa_back_status_type back_status,
   output      logic [ADDR_W-1:0]    ram_rd_addr,
   input  wire logic [WEIGHT_W-1:0]  ram_rd_data,
   twwa_rsp_if.source                rsp_if
);
   twwa_state_type      state_ff, state_in;
   twwa_job_type        job_ff, job_in;
   logic [LEN_W-1:0]    idx_ff, idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [SUM_W-1:0]    quot_ff, quot_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [DIVCNT_W-1:0] step_ff, step_in;
   logic                out_vld_ff, out_vld_in;
   twwa_job_type        out_job_ff;
   logic [WEIGHT_W-1:0] out_avg_ff;
   logic                load_out;
   logic [LEN_W:0]      trial;

   assign ram_rd_addr          = {job_ff.tank, idx_ff[POS_W-1:0]};
   assign back_status.sum_busy = (state_ff == BK_SUM) || (state_ff == BK_IDLE && !queue_empty);
   assign trial                = {rem_ff, quot_ff[SUM_W-1]};

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      idx_in    = idx_ff;
      rd_vld_in = 1'b0;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      pop       = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               job_in   = head_job;
               idx_in   = '0;
               quot_in  = '0;
               state_in = BK_SUM;
            end
         end
         BK_SUM: begin
            // Read data arrives in the cycle after its address; the sum is complete
            // once the last read has landed.
            if (rd_vld_ff) begin
               quot_in = quot_ff + SUM_W'(ram_rd_data);
            end
            if (idx_ff < job_ff.count) begin
               idx_in    = idx_ff + LEN_W'(1);
               rd_vld_in = 1'b1;
            end else if (!rd_vld_ff) begin
               rem_in   = '0;
               step_in  = '0;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (trial >= {1'b0, job_ff.count}) begin
               rem_in = LEN_W'(trial - {1'b0, job_ff.count});
               quot_in = {quot_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[LEN_W-1:0];
               quot_in = {quot_ff[SUM_W-2:0], 1'b0};
            end
            step_in = step_ff + DIVCNT_W'(1);
            if (step_ff == DIVCNT_W'(SUM_W - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!out_vld_ff || rsp_if.ready) begin
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
      if (load_out) begin
         out_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (load_out) begin
         out_job_ff <= job_ff;
         out_avg_ff <= quot_ff[WEIGHT_W-1:0];
      end
   end

   assign rsp_if.valid            = out_vld_ff;
   assign rsp_if.tank_echo        = out_job_ff.tank_echo;
   assign rsp_if.average_weight   = out_avg_ff;
   assign rsp_if.readings_used    = out_job_ff.count;
   assign rsp_if.tank_present     = out_job_ff.present;
   assign rsp_if.presence_changed = out_job_ff.changed;
endmodule
`default_nettype wire

### hw/rtl/tank_weight_window_average_core.sv
// ----------------------------------------------------------------------------
// tank_weight_window_average_core
// Per-tank moving average of load-cell weights with restart on presence change.
// ----------------------------------------------------------------------------
// Each sample word updates its tank's ring and yields one result word with the
// truncated mean of the tank's valid readings. The count ring entries (count
// is readings_used, 1 to 32) are read one at a time on the single read port of
// the ring RAM, then 21 steps of a bit-serial divider follow. A new sample is
// taken once the previous one has left the ring sweep, so the result register
// and divider overlap the next sample. The user must write window_len through
// csr_write_en/csr_write_data only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module tank_weight_window_average_core import twwa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   twwa_req_if.sink         req_if,
   twwa_rsp_if.source       rsp_if,
   input  wire logic        csr_write_en,
   input  wire logic [5:0]  csr_write_data
);
   logic [LEN_W-1:0]     window_ff;
   logic                 push;
   logic                 pop;
   logic                 queue_empty;
   twwa_job_type         push_job;
   twwa_job_type         head_job;
   twwa_back_status_type back_status;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [WEIGHT_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [WEIGHT_W-1:0]  ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_write_en) begin
         window_ff <= csr_write_data;
      end
   end

   twwa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .window_len  (window_ff),
      .queue_empty (queue_empty),
      .back_status (back_status),
      .push        (push),
      .job         (push_job),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   twwa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   twwa_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   twwa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .back_status (back_status),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_if      (rsp_if)
   );
endmodule
`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-tank windowed weight averager.
// ----------------------------------------------------------------------------
// Sample words are driven on the request channel with random gaps, and result
// words are taken with random back-pressure. A scoreboard keeps its own copy of
// every tank's ring and presence state and predicts each result word in order.
// The window length is changed between phases while the block is idle. The
// settings covered are the reset value, the out-of-range values and both ends of
// the legal range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
   bit [4:0]  tank;
   bit [15:0] weight;
   bit        inserted;
   bit        sensored;
} sample_t;

typedef struct {
   bit [4:0]  tank;
   bit [15:0] average;
   bit [5:0]  used;
   bit        present;
   bit        changed;
} average_t;

class average_scoreboard;
   bit [15:0] ring[32][32];
   bit        written[32][32];
   int        wpos[32];
   bit        full[32];
   bit        pres[32];
   bit [5:0]  window;
   average_t  pending[$];
   int        errors;

   function new();
      window = twwa_pkg::WINDOW_RESET;
      errors = 0;
      for (int t = 0; t < 32; t++) begin
         wpos[t] = 0;
         full[t] = 0;
         pres[t] = 0;
         for (int i = 0; i < 32; i++) written[t][i] = 0;
      end
   endfunction

   // Works out the result word of one sample. With commit set, the tank state is
   // updated as well. Reports whether the mean would cover a never-written entry.
   function automatic bit predict(input sample_t s, input bit commit, output average_t r);
      int        t, len, p, np, cnt;
      bit        f, pr, ch, unsafe;
      bit [31:0] sum;
      t = s.tank;
      len = (window == 0) ? 1 : ((window > 32) ? 32 : window);
      p = wpos[t];
      f = full[t];
      pr = pres[t];
      ch = 0;
      unsafe = 0;
      sum = 0;
      if (s.sensored && pr != s.inserted) begin
         p = 0;
         f = 0;
         ch = 1;
      end
      if (s.sensored) pr = s.inserted;
      if (p >= len) p = 0;
      if (p == len - 1) f = 1;
      np = (p + 1) % len;
      cnt = f ? len : np;
      if (cnt == 0) cnt = len;
      for (int i = 0; i < cnt; i++) begin
         if (i == p) begin
            sum += s.weight;
         end else begin
            sum += ring[t][i];
            if (!written[t][i]) unsafe = 1;
         end
      end
      r.tank = s.tank;
      r.average = 16'(sum / cnt);
      r.used = 6'(cnt);
      r.present = pr;
      r.changed = ch;
      if (commit) begin
         ring[t][p] = s.weight;
         written[t][p] = 1;
         wpos[t] = np;
         full[t] = f;
         pres[t] = pr;
      end
      return unsafe;
   endfunction

   function void note_sample(sample_t s);
      average_t r;
      void'(predict(s, 1, r));
      pending.push_back(r);
   endfunction

   function void check_result(average_t got);
      average_t exp;
      if (pending.size() == 0) begin
         $error("result word for tank %0d with no sample outstanding", got.tank);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (got.tank != exp.tank) begin
         $error("tank_echo: expected %0d, actual %0d", exp.tank, got.tank);
         errors++;
      end
      if (got.average != exp.average) begin
         $error("average_weight: expected %0d, actual %0d", exp.average, got.average);
         errors++;
      end
      if (got.used != exp.used) begin
         $error("readings_used: expected %0d, actual %0d", exp.used, got.used);
         errors++;
      end
      if (got.present != exp.present) begin
         $error("tank_present: expected %0d, actual %0d", exp.present, got.present);
         errors++;
      end
      if (got.changed != exp.changed) begin
         $error("presence_changed: expected %0d, actual %0d", exp.changed, got.changed);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import twwa_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_write_en;
   logic [5:0] csr_write_data;
   int         send_idle_pct;
   int         take_idle_pct;

   twwa_req_if req_if ();
   twwa_rsp_if rsp_if ();

   average_scoreboard board;

   tank_weight_window_average_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: check accepted words, then pick the next ready level.
   always @(posedge clock) begin
      average_t got;
      if (rsp_if.valid && rsp_if.ready) begin
         got.tank = rsp_if.tank_echo;
         got.average = rsp_if.average_weight;
         got.used = rsp_if.readings_used;
         got.present = rsp_if.tank_present;
         got.changed = rsp_if.presence_changed;
         board.check_result(got);
      end
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= take_idle_pct);
   end

   task automatic drain();
      req_if.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_window(bit [5:0] value);
      drain();
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.window = value;
   endtask

   task automatic send_sample(sample_t s);
      average_t r;
      // A sample whose mean would cover a never-written entry gets its presence
      // flipped, so the ring restarts instead.
      if (board.predict(s, 0, r)) begin
         s.sensored = 1;
         s.inserted = !board.pres[s.tank];
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.tank_index <= s.tank;
      req_if.weight_sample <= s.weight;
      req_if.inserted_now <= s.inserted;
      req_if.has_sensor <= s.sensored;
      do @(posedge clock); while (!req_if.ready);
      board.note_sample(s);
   endtask

   task automatic send_fields(int tank, int weight, bit ins, bit sens);
      sample_t s;
      s.tank = 5'(tank);
      s.weight = 16'(weight);
      s.inserted = ins;
      s.sensored = sens;
      send_sample(s);
   endtask

   task automatic send_random(int count);
      sample_t s;
      int      focus;
      focus = $urandom_range(31);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 70) s.tank = 5'(focus + $urandom_range(2));
         else s.tank = 5'($urandom);
         if ($urandom_range(99) < 3) focus = $urandom_range(31);
         case ($urandom_range(3))
            0: s.weight = 16'($urandom);
            1: s.weight = 16'(16'hFFFF - $urandom_range(255));
            2: s.weight = 16'($urandom_range(255));
            default: s.weight = 16'(16'h8000 + $urandom_range(4095));
         endcase
         s.sensored = 1'($urandom_range(1));
         // Presence flips are rare so rings get to fill up.
         s.inserted = ($urandom_range(99) < 8) ? !board.pres[s.tank] : board.pres[s.tank];
         send_sample(s);
      end
   endtask

   initial begin
      board = new();
      send_idle_pct = 0;
      take_idle_pct = 0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.tank_index = '0;
      req_if.weight_sample = '0;
      req_if.inserted_now = 1'b0;
      req_if.has_sensor = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset window length.
      send_fields(0, 16'hFFFF, 0, 0);
      send_fields(0, 16'hFFFF, 0, 0);
      send_fields(0, 0, 0, 0);
      send_fields(31, 16'hFFFF, 1, 1);
      send_fields(31, 16'h0001, 1, 1);
      send_fields(31, 16'h8000, 0, 1);
      send_fields(31, 16'h1234, 0, 0);
      send_fields(7, 16'h5555, 1, 0);
      send_fields(7, 16'hAAAA, 1, 1);
      set_window(6'd32);
      for (int i = 0; i < 10; i++) send_fields(3, 16'hFFFF - i, 0, 0);
      // Shrinking the window leaves a stale write position in tank 3.
      set_window(6'd4);
      send_fields(3, 16'h0100, 0, 0);
      send_fields(3, 16'h0200, 0, 0);
      set_window(6'd0);
      send_fields(3, 16'h0300, 0, 0);
      send_fields(3, 16'h0400, 1, 1);
      set_window(6'd63);
      send_fields(3, 16'h0500, 1, 1);

      send_idle_pct = 36;
      take_idle_pct = 84;
      set_window(6'd1);
      send_random(120);
      set_window(6'd32);
      send_random(250);

      send_idle_pct = 84;
      take_idle_pct = 36;
      set_window(6'd5);
      send_random(200);
      // Let the block run dry once in the middle of a phase.
      drain();
      send_random(60);

      send_idle_pct = 0;
      take_idle_pct = 0;
      set_window(6'd40);
      send_random(200);
      set_window(6'd17);
      send_random(150);
      set_window(6'd3);
      send_random(150);

      drain();
      if (board.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
